[rtl/lrc_pkg.sv]
// ----------------------------------------------------------------------------
// Line/rectangle clip package
// Shared widths, register indexes, a pipeline type and a helper function.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 16;
    localparam int C_W        = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int H_W        = C_W + 1;
    localparam int S_W        = C_W + 2;
    localparam int POINT_W    = 24;
    localparam int NUM_W      = H_W + FRAC_BITS;
    localparam int DEN_W      = COORD_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_RECT_X0 = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_Y0 = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_X1 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_Y1 = CFG_ADDR_W'(3);

    typedef struct packed {
        logic               hit;
        logic               l0_div_x;
        logic [POINT_W-1:0] l0_exact;
        logic               l1_div_x;
        logic [POINT_W-1:0] l1_exact;
    } lrc_side_t;

    // Integer coordinate scaled to fixed point, kept to the output width.
    function automatic logic [POINT_W-1:0] fixed_coord(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W+FRAC_BITS-1:0] w;
        w = (COORD_W+FRAC_BITS)'(v) <<< FRAC_BITS;
        return w[POINT_W-1:0];
    endfunction

endpackage

[rtl/lrc_div.sv]
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of |num| * 2^FRAC_BITS by |den|, DIV_STEP quotient
// bits per stage, with the quotient sign carried alongside.
// ----------------------------------------------------------------------------
module lrc_div import lrc_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [H_W-1:0]   num,
    input  logic signed [DEN_W-1:0] den,
    output logic [NUM_W-1:0]        q_mag,
    output logic                    q_neg
);

    logic [NUM_W-1:0] n_reg [0:DIV_STAGES];
    logic [DEN_W:0]   r_reg [0:DIV_STAGES];
    logic [DEN_W-1:0] d_reg [0:DIV_STAGES];
    logic             g_reg [0:DIV_STAGES];

    logic [H_W-1:0]   num_abs;
    logic [DEN_W-1:0] den_abs;

    assign num_abs = num[H_W-1] ? H_W'(-num) : H_W'(num);
    assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // The numerator is the negated line value, so it is negative when num > 0.
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0] <= NUM_W'(num_abs) << FRAC_BITS;
            r_reg[0] <= '0;
            d_reg[0] <= den_abs;
            g_reg[0] <= (!num[H_W-1] && (num != '0)) ^ den[DEN_W-1];
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
        logic [NUM_W-1:0] n_next;
        logic [DEN_W:0]   r_next;

        always_comb begin
            n_next = n_reg[k-1];
            r_next = r_reg[k-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                if ((k - 1) * DIV_STEP + j < NUM_W) begin
                    r_next = {r_next[DEN_W-1:0], n_next[NUM_W-1]};
                    n_next = {n_next[NUM_W-2:0], 1'b0};
                    if (r_next >= {1'b0, d_reg[k-1]}) begin
                        r_next    = r_next - {1'b0, d_reg[k-1]};
                        n_next[0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
                d_reg[k] <= d_reg[k-1];
                g_reg[k] <= g_reg[k-1];
            end
        end
    end

    assign q_mag = n_reg[DIV_STAGES];
    assign q_neg = g_reg[DIV_STAGES];

endmodule

[rtl/lrc_front.sv]
// ----------------------------------------------------------------------------
// Clip front end
// Corner products, side values, crossing tests and selection of the two
// divisions, over four register stages.
// ----------------------------------------------------------------------------
module lrc_front import lrc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] line_a,
    input  logic signed [COORD_W-1:0] line_b,
    input  logic signed [C_W-1:0]     line_c,
    input  logic signed [COORD_W-1:0] rect_x0,
    input  logic signed [COORD_W-1:0] rect_y0,
    input  logic signed [COORD_W-1:0] rect_x1,
    input  logic signed [COORD_W-1:0] rect_y1,
    output logic                      out_valid,
    output lrc_side_t                 side,
    output logic signed [H_W-1:0]     num0,
    output logic signed [DEN_W-1:0]   den0,
    output logic signed [H_W-1:0]     num1,
    output logic signed [DEN_W-1:0]   den1
);

    logic [3:0] valid_reg;

    // Stage 1: products.
    logic signed [PROD_W-1:0]  ax0_reg, ax1_reg, by0_reg, by1_reg;
    logic signed [C_W-1:0]     c1_reg;
    logic signed [COORD_W-1:0] a1_reg, b1_reg;
    // Stage 2: edge line values.
    logic signed [H_W-1:0]     hb_reg, ht_reg, vr_reg, vl_reg;
    logic signed [PROD_W-1:0]  ax0_2_reg, ax1_2_reg;
    logic signed [COORD_W-1:0] a2_reg, b2_reg;
    // Stage 3: corner signs.
    logic [3:0]                pos_reg, neg_reg;
    logic signed [H_W-1:0]     hb3_reg, ht3_reg, vr3_reg, vl3_reg;
    logic signed [COORD_W-1:0] a3_reg, b3_reg;
    // Stage 4: selected divisions.
    lrc_side_t                 side_reg;
    logic signed [H_W-1:0]     num0_reg, num1_reg;
    logic signed [DEN_W-1:0]   den0_reg, den1_reg;

    logic signed [S_W-1:0] s_corner [0:3];
    logic [3:0]            pos_next, neg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax0_reg <= line_a * rect_x0;
            ax1_reg <= line_a * rect_x1;
            by0_reg <= line_b * rect_y0;
            by1_reg <= line_b * rect_y1;
            c1_reg  <= line_c;
            a1_reg  <= line_a;
            b1_reg  <= line_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hb_reg    <= H_W'(c1_reg) + H_W'(by0_reg);
            ht_reg    <= H_W'(c1_reg) + H_W'(by1_reg);
            vr_reg    <= H_W'(c1_reg) + H_W'(ax1_reg);
            vl_reg    <= H_W'(c1_reg) + H_W'(ax0_reg);
            ax0_2_reg <= ax0_reg;
            ax1_2_reg <= ax1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
        end
    end

    // Corners in order: (x0,y0), (x1,y0), (x1,y1), (x0,y1).
    always_comb begin
        s_corner[0] = S_W'(hb_reg) + S_W'(ax0_2_reg);
        s_corner[1] = S_W'(hb_reg) + S_W'(ax1_2_reg);
        s_corner[2] = S_W'(ht_reg) + S_W'(ax1_2_reg);
        s_corner[3] = S_W'(ht_reg) + S_W'(ax0_2_reg);
        for (int i = 0; i < 4; i++) begin
            neg_next[i] = s_corner[i][S_W-1];
            pos_next[i] = !s_corner[i][S_W-1] && (s_corner[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            hb3_reg <= hb_reg;
            ht3_reg <= ht_reg;
            vr3_reg <= vr_reg;
            vl3_reg <= vl_reg;
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
        end
    end

    logic [3:0]              crossed;
    logic [2:0]              count;
    logic [1:0]              e0, e1;
    logic                    found0, found1;
    logic signed [H_W-1:0]   edge_num [0:3];
    logic signed [DEN_W-1:0] edge_den [0:3];
    logic [POINT_W-1:0]      edge_exact [0:3];
    lrc_side_t               side_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            crossed[i] = (neg_reg[i] && pos_reg[(i + 1) % 4])
                       || (pos_reg[i] && neg_reg[(i + 1) % 4]);
        end
        count  = '0;
        e0     = '0;
        e1     = '0;
        found0 = 1'b0;
        found1 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (crossed[i]) begin
                count = count + 3'd1;
                if (!found0) begin
                    e0     = 2'(i);
                    found0 = 1'b1;
                end else if (!found1) begin
                    e1     = 2'(i);
                    found1 = 1'b1;
                end
            end
        end

        // Bottom, right, top, left.
        edge_num[0]   = hb3_reg;
        edge_den[0]   = a3_reg;
        edge_exact[0] = fixed_coord(rect_y0);
        edge_num[1]   = vr3_reg;
        edge_den[1]   = b3_reg;
        edge_exact[1] = fixed_coord(rect_x1);
        edge_num[2]   = ht3_reg;
        edge_den[2]   = a3_reg;
        edge_exact[2] = fixed_coord(rect_y1);
        edge_num[3]   = vl3_reg;
        edge_den[3]   = b3_reg;
        edge_exact[3] = fixed_coord(rect_x0);

        side_next.hit      = (count == 3'd2);
        side_next.l0_div_x = !e0[0];
        side_next.l0_exact = edge_exact[e0];
        side_next.l1_div_x = !e1[0];
        side_next.l1_exact = edge_exact[e1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            num0_reg <= edge_num[e0];
            den0_reg <= edge_den[e0];
            num1_reg <= edge_num[e1];
            den1_reg <= edge_den[e1];
        end
    end

    assign out_valid = valid_reg[3];
    assign side      = side_reg;
    assign num0      = num0_reg;
    assign den0      = den0_reg;
    assign num1      = num1_reg;
    assign den1      = den1_reg;

endmodule

[rtl/line_rectangle_clip_top.sv]
// ----------------------------------------------------------------------------
// Line/rectangle clip
// Clips one line a*x+b*y+c=0 per word against a configured rectangle and
// gives the two crossing points in Q16.8.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_line_a/b/c          | in
//  result  | m_valid, m_ready, m_hit, m_point_*      | out
//  config  | cfg_we, cfg_addr, cfg_wdata             | in
//
// One word is accepted per cycle while s_ready is high; the divider is
// pipelined, with DIV_STEP quotient bits per stage.
// The whole pipeline holds while a result waits and m_ready is low.
// Reset clears the valid bits and loads the default rectangle.
// ----------------------------------------------------------------------------
module line_rectangle_clip_top import lrc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [COORD_W-1:0]         cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COORD_W-1:0]  s_line_a,
    input  logic signed [COORD_W-1:0]  s_line_b,
    input  logic signed [C_W-1:0]      s_line_c,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic signed [POINT_W-1:0]  m_point_a_x,
    output logic signed [POINT_W-1:0]  m_point_a_y,
    output logic signed [POINT_W-1:0]  m_point_b_x,
    output logic signed [POINT_W-1:0]  m_point_b_y
);

    logic signed [COORD_W-1:0] rect_x0_reg, rect_y0_reg, rect_x1_reg, rect_y1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_x0_reg <= COORD_W'(0);
            rect_y0_reg <= COORD_W'(0);
            rect_x1_reg <= COORD_W'(1023);
            rect_y1_reg <= COORD_W'(1023);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RECT_X0: rect_x0_reg <= cfg_wdata;
                REG_RECT_Y0: rect_y0_reg <= cfg_wdata;
                REG_RECT_X1: rect_x1_reg <= cfg_wdata;
                REG_RECT_Y1: rect_y1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic                    f_valid;
    lrc_side_t               f_side;
    logic signed [H_W-1:0]   f_num0, f_num1;
    logic signed [DEN_W-1:0] f_den0, f_den1;

    lrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .line_a    (s_line_a),
        .line_b    (s_line_b),
        .line_c    (s_line_c),
        .rect_x0   (rect_x0_reg),
        .rect_y0   (rect_y0_reg),
        .rect_x1   (rect_x1_reg),
        .rect_y1   (rect_y1_reg),
        .out_valid (f_valid),
        .side      (f_side),
        .num0      (f_num0),
        .den0      (f_den0),
        .num1      (f_num1),
        .den1      (f_den1)
    );

    logic [NUM_W-1:0] q0_mag, q1_mag;
    logic             q0_neg, q1_neg;

    lrc_div u_div0 (
        .aclk  (aclk),
        .en    (en),
        .num   (f_num0),
        .den   (f_den0),
        .q_mag (q0_mag),
        .q_neg (q0_neg)
    );

    lrc_div u_div1 (
        .aclk  (aclk),
        .en    (en),
        .num   (f_num1),
        .den   (f_den1),
        .q_mag (q1_mag),
        .q_neg (q1_neg)
    );

    // Side data and valid bits follow the divider latency.
    lrc_side_t          side_reg  [0:DIV_STAGES];
    logic [DIV_STAGES:0] dvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvalid_reg <= '0;
        end else if (en) begin
            dvalid_reg <= {dvalid_reg[DIV_STAGES-1:0], f_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= f_side;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    lrc_side_t          sd;
    logic [NUM_W-1:0]   q0_s, q1_s;
    logic [POINT_W-1:0] q0, q1;
    logic [POINT_W-1:0] ax_next, ay_next, bx_next, by_next;

    always_comb begin
        sd      = side_reg[DIV_STAGES];
        q0_s    = q0_neg ? NUM_W'(-q0_mag) : q0_mag;
        q1_s    = q1_neg ? NUM_W'(-q1_mag) : q1_mag;
        q0      = q0_s[POINT_W-1:0];
        q1      = q1_s[POINT_W-1:0];
        ax_next = '0;
        ay_next = '0;
        bx_next = '0;
        by_next = '0;
        if (sd.hit) begin
            ax_next = sd.l0_div_x ? q0 : sd.l0_exact;
            ay_next = sd.l0_div_x ? sd.l0_exact : q0;
            bx_next = sd.l1_div_x ? q1 : sd.l1_exact;
            by_next = sd.l1_div_x ? sd.l1_exact : q1;
        end
    end

    logic                      hit_reg;
    logic [POINT_W-1:0]        ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dvalid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= sd.hit;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = hit_reg;
    assign m_point_a_x = ax_reg;
    assign m_point_a_y = ay_reg;
    assign m_point_b_x = bx_reg;
    assign m_point_b_y = by_reg;

endmodule
